@@ design/frd_pkg.sv @@
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants of the fold region detector.
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam logic [2:0] KIND_EMPTY  = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_INDENT = 3'd4;
  localparam logic [2:0] KIND_IGNORE = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  line_kind;
    logic [11:0] line_indent;
    logic [31:0] line_start;
    logic [31:0] line_end;
    logic [31:0] first_text;
    logic [31:0] buffer_end;
    logic        final_line;
  } line_item_t;

  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        none_found;
    logic        overflowed;
    logic        end_of_list;
  } range_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [11:0] indent;
  } stack_entry_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
  } range_pair_t;

  // One range from the front part, or the end-of-buffer token when last is set.
  typedef struct packed {
    logic        last;
    logic        overflowed;
    range_pair_t pair;
  } fold_event_t;

  function automatic logic pair_less(input range_pair_t a, input range_pair_t b);
    return (a.start < b.start) || ((a.start == b.start) && (a.stop < b.stop));
  endfunction

endpackage

@@ design/frd_ram.sv @@
// ----------------------------------------------------------------------------
// frd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/frd_front.sv @@
// ----------------------------------------------------------------------------
// frd_front
// Line sequencer: keeps the marker and indent stacks and issues ranges.
// ----------------------------------------------------------------------------
module frd_front #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  frd_pkg::line_item_t line,
  output logic                ev_valid,
  input  logic                ev_ready,
  output frd_pkg::fold_event_t ev
);
  import frd_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLOSE_RD = 4'd1;
  localparam logic [3:0] S_CLOSE    = 4'd2;
  localparam logic [3:0] S_ACT      = 4'd3;
  localparam logic [3:0] S_STOP_RD  = 4'd4;
  localparam logic [3:0] S_STOP     = 4'd5;
  localparam logic [3:0] S_DONE     = 4'd6;
  localparam logic [3:0] S_FLUSH_RD = 4'd7;
  localparam logic [3:0] S_FLUSH    = 4'd8;
  localparam logic [3:0] S_TOKEN    = 4'd9;

  logic [3:0]     state;
  line_item_t     item;
  logic [SCW-1:0] mdepth;
  logic [SCW-1:0] idepth;
  logic [SCW-1:0] scan;
  logic [31:0]    prev_end;
  logic           ovf;

  logic [SCW-1:0] i_dec;
  logic [SCW-1:0] scan_dec;
  logic           m_we;
  logic           i_we;
  stack_entry_t   new_entry;
  stack_entry_t   m_rd;
  stack_entry_t   i_rd;
  logic           close_hit;
  logic           close_emit;
  logic           stop_hit;

  assign i_dec     = idepth - SCW'(1);
  assign scan_dec  = scan - SCW'(1);
  assign new_entry = '{offset: item.line_end, indent: item.line_indent};
  assign m_we = (state == S_ACT) && (item.line_kind == KIND_START) &&
                (mdepth != SCW'(STACK_DEPTH));
  assign i_we = (state == S_ACT) && (item.line_kind == KIND_INDENT) &&
                (idepth != SCW'(STACK_DEPTH));

  frd_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(STACK_DEPTH)) u_marker_ram (
    .clk     (clk),
    .wr_en   (m_we),
    .wr_addr (mdepth[SAW-1:0]),
    .wr_data (new_entry),
    .rd_addr (scan_dec[SAW-1:0]),
    .rd_data (m_rd)
  );

  frd_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(STACK_DEPTH)) u_indent_ram (
    .clk     (clk),
    .wr_en   (i_we),
    .wr_addr (idepth[SAW-1:0]),
    .wr_data (new_entry),
    .rd_addr (i_dec[SAW-1:0]),
    .rd_data (i_rd)
  );

  assign close_hit  = item.line_indent <= i_rd.indent;
  assign close_emit = i_rd.offset < prev_end;
  assign stop_hit   = m_rd.indent == item.line_indent;
  assign full       = state != S_IDLE;

  always_comb begin
    ev       = '0;
    ev_valid = 1'b0;
    case (state)
      S_CLOSE: begin
        ev.pair  = '{start: i_rd.offset, stop: prev_end};
        ev_valid = close_hit && close_emit;
      end
      S_STOP: begin
        ev.pair  = '{start: m_rd.offset, stop: item.first_text};
        ev_valid = stop_hit;
      end
      S_FLUSH: begin
        ev.pair  = '{start: i_rd.offset, stop: item.buffer_end};
        ev_valid = 1'b1;
      end
      S_TOKEN: begin
        ev.last       = 1'b1;
        ev.overflowed = ovf;
        ev_valid      = 1'b1;
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mdepth   <= '0;
      idepth   <= '0;
      scan     <= '0;
      prev_end <= '0;
      ovf      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (push) begin
            item <= line;
            if (!(line.line_kind inside {KIND_EMPTY, KIND_IGNORE}) && idepth != '0) begin
              state <= S_CLOSE_RD;
            end else begin
              state <= S_ACT;
            end
          end
        end
        S_CLOSE_RD: begin
          state <= S_CLOSE;
        end
        S_CLOSE: begin
          if (!close_hit) begin
            state <= S_ACT;
          end else if (!close_emit || ev_ready) begin
            idepth <= i_dec;
            state  <= (i_dec == '0) ? S_ACT : S_CLOSE_RD;
          end
        end
        S_ACT: begin
          case (item.line_kind)
            KIND_START: begin
              if (m_we) mdepth <= mdepth + SCW'(1);
              else      ovf <= 1'b1;
              state <= S_DONE;
            end
            KIND_INDENT: begin
              if (i_we) idepth <= idepth + SCW'(1);
              else      ovf <= 1'b1;
              state <= S_DONE;
            end
            KIND_STOP: begin
              if (mdepth != '0) begin
                scan  <= mdepth;
                state <= S_STOP_RD;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_STOP_RD: begin
          state <= S_STOP;
        end
        S_STOP: begin
          if (stop_hit) begin
            if (ev_ready) begin
              mdepth <= scan_dec;
              state  <= S_DONE;
            end
          end else begin
            scan  <= scan_dec;
            state <= (scan_dec == '0) ? S_DONE : S_STOP_RD;
          end
        end
        S_DONE: begin
          prev_end <= item.line_end;
          if (!item.final_line) state <= S_IDLE;
          else if (idepth != '0) state <= S_FLUSH_RD;
          else state <= S_TOKEN;
        end
        S_FLUSH_RD: begin
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          // close open indent blocks at the buffer end, innermost first
          if (ev_ready) begin
            idepth <= i_dec;
            state  <= (i_dec == '0) ? S_TOKEN : S_FLUSH_RD;
          end
        end
        S_TOKEN: begin
          if (ev_ready) begin
            mdepth   <= '0;
            idepth   <= '0;
            prev_end <= '0;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_mdepth_bound: assert property (@(posedge clk) disable iff (rst)
    mdepth <= SCW'(STACK_DEPTH))
    else $error("marker stack depth beyond its size");

  a_idepth_bound: assert property (@(posedge clk) disable iff (rst)
    idepth <= SCW'(STACK_DEPTH))
    else $error("indent stack depth beyond its size");

  a_ev_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(ev))
    else $error("range event changed while waiting");

endmodule

@@ design/frd_queue.sv @@
// ----------------------------------------------------------------------------
// frd_queue
// Short FIFO of range events between the front and the back part.
// ----------------------------------------------------------------------------
module frd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frd_pkg::fold_event_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output frd_pkg::fold_event_t out_data
);
  import frd_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  fold_event_t    slots [QUEUE_DEPTH];
  logic [QW-1:0]  wptr;
  logic [QW-1:0]  rptr;
  logic [QC-1:0]  count;
  logic           wr;
  logic           rd;

  assign in_ready  = count != QC'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + QW'(1);
      if (rd) rptr <= rptr + QW'(1);
      if (wr && !rd)      count <= count + QC'(1);
      else if (rd && !wr) count <= count - QC'(1);
    end
  end

endmodule

@@ design/frd_back.sv @@
// ----------------------------------------------------------------------------
// frd_back
// Range table kept sorted by insertion; crossing filter and result output.
// ----------------------------------------------------------------------------
module frd_back #(
  parameter int MAX_RANGES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ev_valid,
  output logic                  ev_ready,
  input  frd_pkg::fold_event_t  ev,
  output logic                  empty,
  input  logic                  pop,
  output frd_pkg::range_item_t  result
);
  import frd_pkg::*;

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  localparam logic [3:0] B_IDLE    = 4'd0;
  localparam logic [3:0] B_INS_RD  = 4'd1;
  localparam logic [3:0] B_INS     = 4'd2;
  localparam logic [3:0] B_SCAN_RD = 4'd3;
  localparam logic [3:0] B_SCAN    = 4'd4;
  localparam logic [3:0] B_CHK     = 4'd5;
  localparam logic [3:0] B_POP_RD  = 4'd6;
  localparam logic [3:0] B_POP     = 4'd7;
  localparam logic [3:0] B_EMIT    = 4'd8;
  localparam logic [3:0] B_NEXT    = 4'd9;
  localparam logic [3:0] B_LAST    = 4'd10;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] j;
  logic [CW-1:0] i;
  logic [CW-1:0] nest;
  logic          tovf;
  logic          run_ovf;
  logic          pend_valid;
  logic          out_valid;
  range_pair_t   v;
  range_pair_t   p;
  range_pair_t   pend;
  logic [31:0]   nest_top;
  range_item_t   out_reg;

  logic [CW-1:0] j_dec;
  logic [CW-1:0] nest_dec;
  logic          shift;
  logic          r_we;
  range_pair_t   r_wr_data;
  logic [AW-1:0] r_rd_addr;
  range_pair_t   r_rd;
  logic [31:0]   n_rd;
  logic          pop_c;
  logic          skip_c;
  logic          keep;
  logic          n_we;
  logic          out_free;
  logic          out_load;

  assign j_dec     = j - CW'(1);
  assign nest_dec  = nest - CW'(1);
  assign shift     = (j != '0) && pair_less(v, r_rd);
  assign r_we      = state == B_INS;
  assign r_wr_data = shift ? r_rd : v;
  assign r_rd_addr = (state == B_SCAN_RD) ? i[AW-1:0] : j_dec[AW-1:0];

  frd_ram #(.WIDTH($bits(range_pair_t)), .DEPTH(MAX_RANGES)) u_range_ram (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (j[AW-1:0]),
    .wr_data (r_wr_data),
    .rd_addr (r_rd_addr),
    .rd_data (r_rd)
  );

  assign pop_c  = (nest != '0) && (nest_top <= p.start);
  assign skip_c = (nest != '0) && (nest_top < p.stop);
  assign keep   = !pop_c && !skip_c;
  assign n_we   = (state == B_CHK) && keep;

  frd_ram #(.WIDTH(32), .DEPTH(MAX_RANGES)) u_nest_ram (
    .clk     (clk),
    .wr_en   (n_we),
    .wr_addr (nest[AW-1:0]),
    .wr_data (p.stop),
    .rd_addr (nest_dec[AW-1:0]),
    .rd_data (n_rd)
  );

  assign ev_ready = state == B_IDLE;
  assign empty    = !out_valid;
  assign result   = out_reg;
  assign out_free = !out_valid || pop;
  assign out_load = ((state == B_EMIT) || (state == B_LAST)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      count      <= '0;
      j          <= '0;
      i          <= '0;
      nest       <= '0;
      tovf       <= 1'b0;
      run_ovf    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !pop);
      case (state)
        B_IDLE: begin
          if (ev_valid) begin
            if (ev.last) begin
              run_ovf    <= tovf || ev.overflowed;
              i          <= '0;
              nest       <= '0;
              pend_valid <= 1'b0;
              state      <= (count == '0) ? B_LAST : B_SCAN_RD;
            end else if (count == CW'(MAX_RANGES)) begin
              tovf <= 1'b1;
            end else begin
              v     <= ev.pair;
              j     <= count;
              state <= (count == '0) ? B_INS : B_INS_RD;
            end
          end
        end
        B_INS_RD: begin
          state <= B_INS;
        end
        B_INS: begin
          // move the larger neighbor up one slot, or drop the new pair in place
          if (shift) begin
            j     <= j_dec;
            state <= B_INS_RD;
          end else begin
            count <= count + CW'(1);
            state <= B_IDLE;
          end
        end
        B_SCAN_RD: begin
          state <= B_SCAN;
        end
        B_SCAN: begin
          p     <= r_rd;
          state <= B_CHK;
        end
        B_CHK: begin
          if (pop_c) begin
            nest <= nest_dec;
            if (nest_dec != '0) state <= B_POP_RD;
          end else if (skip_c) begin
            state <= B_NEXT;
          end else begin
            nest     <= nest + CW'(1);
            nest_top <= p.stop;
            if (pend_valid) begin
              state <= B_EMIT;
            end else begin
              pend       <= p;
              pend_valid <= 1'b1;
              state      <= B_NEXT;
            end
          end
        end
        B_POP_RD: begin
          state <= B_POP;
        end
        B_POP: begin
          nest_top <= n_rd;
          state    <= B_CHK;
        end
        B_EMIT: begin
          if (out_free) begin
            out_reg   <= '{range_start: pend.start, range_end: pend.stop, none_found: 1'b0,
                           overflowed: run_ovf, end_of_list: 1'b0};
            pend      <= p;
            state     <= B_NEXT;
          end
        end
        B_NEXT: begin
          i     <= i + CW'(1);
          state <= (i + CW'(1) == count) ? B_LAST : B_SCAN_RD;
        end
        B_LAST: begin
          if (out_free) begin
            if (pend_valid) begin
              out_reg <= '{range_start: pend.start, range_end: pend.stop, none_found: 1'b0,
                           overflowed: run_ovf, end_of_list: 1'b1};
            end else begin
              out_reg <= '{range_start: 32'd0, range_end: 32'd0, none_found: 1'b1,
                           overflowed: run_ovf, end_of_list: 1'b1};
            end
            count     <= '0;
            nest      <= '0;
            tovf      <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES))
    else $error("range table count beyond its size");

  a_nest_bound: assert property (@(posedge clk) disable iff (rst)
    nest <= count)
    else $error("nesting depth exceeds the number of ranges");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_reg))
    else $error("waiting result changed before its transfer");

endmodule

@@ design/fold_region_detector_top.sv @@
// ----------------------------------------------------------------------------
// fold_region_detector_top
// Foldable range finder over a stream of classified text lines.
// ----------------------------------------------------------------------------
// Each line passes through the line sequencer, which compares indent-stack
// entries while closing blocks and searches marker-stack entries for a stop
// marker; the sequencer stacks read through registered RAMs, one entry at a
// time. The final line also closes every open indent block and then sends the
// end token. Each range found is then inserted into the sorted range table,
// one entry compared at a time, in the background through a four-entry event
// queue. After the final line the table is walked range by range, closing
// nesting levels as it goes; a kept range pushes out the one before it, and
// one result leaves per kept range (or a single none-found result); new lines
// are taken meanwhile until the queue fills.
module fold_region_detector_top #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_RANGES  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  frd_pkg::line_item_t  line,
  output logic                 empty,
  input  logic                 pop,
  output frd_pkg::range_item_t result
);
  import frd_pkg::*;

  fold_event_t f_ev;
  logic        f_valid;
  logic        f_ready;
  fold_event_t b_ev;
  logic        b_valid;
  logic        b_ready;

  frd_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .line     (line),
    .ev_valid (f_valid),
    .ev_ready (f_ready),
    .ev       (f_ev)
  );

  frd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_ev),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_ev)
  );

  frd_back #(.MAX_RANGES(MAX_RANGES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (b_valid),
    .ev_ready (b_ready),
    .ev       (b_ev),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
